// ----- rtl/core/rvps_pkg.sv -----
// Package: shared types and constants for the per-slot running variance block.
package rvps_pkg;

   localparam int SampleWidth = 32;
   localparam int CountWidth  = 32;
   localparam int Sq_Width    = 64;
   localparam int VarWidth    = 48;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DIV_MEAN,
      ST_MEAN,
      ST_MUL,
      ST_ACC,
      ST_DIV_VAR,
      ST_VAR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic dividend_neg;
      logic [Sq_Width-1:0] dividend_mag;
      logic [CountWidth-1:0] divisor;
   } div_req_type;

endpackage

// ----- rtl/core/rvps_divider.sv -----
// Divider: unsigned 64 by 32 bit restoring division, one quotient bit a cycle.
module rvps_divider
   import rvps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_req_type           req,
   output logic                  done,
   output logic [Sq_Width-1:0]   quotient
);

   logic [Sq_Width-1:0]   quo_ff, quo_in;
   logic [CountWidth:0]   rem_ff, rem_in;
   logic [CountWidth-1:0] den_ff, den_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountWidth:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CountWidth-1:0], quo_ff[Sq_Width-1]};
      if (req.start) begin
         quo_in  = req.dividend_mag;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[Sq_Width-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[Sq_Width-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/rvps_store.sv -----
// Slot store: one memory holding mean, m2 and missing flag per slot, with a clearing pass at reset.
module rvps_store
   import rvps_pkg::*;
#(
   parameter int Depth = 1024,
   parameter int AddrWidth = 10
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [AddrWidth-1:0]   rd_addr,
   output logic [SampleWidth-1:0] rd_mean,
   output logic [Sq_Width-1:0]    rd_m2,
   output logic                   rd_miss,
   input  logic                   wr_en,
   input  logic [AddrWidth-1:0]   wr_addr,
   input  logic [SampleWidth-1:0] wr_mean,
   input  logic [Sq_Width-1:0]    wr_m2,
   input  logic                   wr_miss,
   output logic                   clear_busy
);

   logic [SampleWidth+Sq_Width:0] mem [Depth];
   logic [AddrWidth:0]            clr_ff;
   logic [SampleWidth+Sq_Width:0] rd_ff;

   assign clear_busy = (clr_ff < (AddrWidth+1)'(Depth));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clear_busy) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy) begin
         mem[clr_ff[AddrWidth-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= {wr_miss, wr_m2, wr_mean};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_mean = rd_ff[SampleWidth-1:0];
   assign rd_m2   = rd_ff[SampleWidth+Sq_Width-1:SampleWidth];
   assign rd_miss = rd_ff[SampleWidth+Sq_Width];

endmodule

// ----- rtl/core/running_variance_per_slot.sv -----
// Top level: per-slot Welford running mean and variance over a slot memory.
//
// Usage:
//   The req_ channel carries one sample for one (chain, element) slot. The
//   rsp_ channel returns exactly one result transaction per request, in order.
//   A request with req_sweep_start advances the shared sample count n
//   (saturating) before its sample is applied.
//   Sequence: a sample that updates a slot reads the slot memory, divides
//   delta by n in a bit-serial divider, multiplies, accumulates m2, then
//   divides m2 by n-1 in the same divider; while n is below two the second
//   division is skipped. Out-of-range, missing or count-zero samples answer
//   without using the divider. The shared serial divider sets the rate;
//   one transaction is in flight at a time and the next request is
//   taken the cycle after the response is taken.
//   Reset: synchronous, active high. After reset a clearing pass zeroes
//   all NUM_CHAINS*NUM_ELEMENTS slots of the slot memory; req_stall stays
//   high until it ends.
//   Stall: the result is held in an output register while rsp_stall is
//   high; a new request is taken once the held result has been taken.
module running_variance_per_slot
   import rvps_pkg::*;
#(
   parameter int NUM_CHAINS = 4,
   parameter int NUM_ELEMENTS = 256
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_chain_index,
   input  logic [7:0]   req_element_index,
   input  logic signed [31:0] req_sample,
   input  logic         req_sample_missing,
   input  logic         req_sweep_start,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [47:0]  rsp_variance,
   output logic         rsp_variance_valid,
   output logic         rsp_slot_missing,
   output logic         rsp_overflow
);

   localparam int Depth     = NUM_CHAINS * NUM_ELEMENTS;
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int ElemWidth = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

   state_type state_ff, state_in;

   logic [CountWidth-1:0]  count_ff, count_in;
   logic [AddrWidth-1:0]   slot_ff, slot_in;
   logic signed [SampleWidth:0] x_ff, x_in;
   logic                   miss_ff, miss_in;
   logic                   inrange_ff, inrange_in;
   logic signed [SampleWidth:0] mean_ff, mean_in;
   logic signed [SampleWidth+1:0] delta_ff, delta_in;
   logic signed [SampleWidth+1:0] dev_ff, dev_in;
   logic [Sq_Width-1:0]    m2_ff, m2_in;
   logic [Sq_Width-1:0]    prod_ff, prod_in;
   logic                   ovf_ff, ovf_in;
   logic [VarWidth-1:0]    var_ff, var_in;
   logic                   vv_ff, vv_in, sm_ff, sm_in, of_ff, of_in;
   logic                   rv_ff, rv_in;

   logic                   clear_busy, wr_en;
   logic [SampleWidth-1:0] rd_mean;
   logic [Sq_Width-1:0]    rd_m2;
   logic                   rd_miss;
   div_req_type            div_req;
   logic                   div_done;
   logic [Sq_Width-1:0]    div_q;

   logic                   accept;
   logic [CountWidth-1:0]  count_next;
   logic                   chain_ok, elem_ok;
   logic [Sq_Width-1:0]    dmag;
   logic signed [SampleWidth+2:0] mnew;
   logic signed [SampleWidth+2:0] dev_full;
   logic [Sq_Width:0]      m2_sum;
   logic [Sq_Width-1:0]    var_full;
   logic [SampleWidth+1:0] delta_mag, dev_mag;

   rvps_store #(.Depth(Depth), .AddrWidth(AddrWidth)) u_store (
      .clock, .reset,
      .rd_addr(slot_ff), .rd_mean, .rd_m2, .rd_miss,
      .wr_en, .wr_addr(slot_ff),
      .wr_mean(mean_ff[SampleWidth-1:0]), .wr_m2(m2_ff), .wr_miss(miss_ff),
      .clear_busy
   );

   rvps_divider u_div (.clock, .reset, .req(div_req), .done(div_done), .quotient(div_q));

   assign req_stall = (state_ff != ST_IDLE) || clear_busy || rv_ff;
   assign accept    = req_valid && !req_stall;

   assign chain_ok = ({30'd0, req_chain_index} < 32'(NUM_CHAINS));
   assign elem_ok  = ({24'd0, req_element_index} < 32'(NUM_ELEMENTS));
   assign count_next = (req_sweep_start && count_ff != '1) ? count_ff + 1'b1 : count_ff;

   assign delta_mag = delta_ff[SampleWidth+1] ? 34'(-delta_ff) : 34'(delta_ff);
   assign dev_mag   = dev_ff[SampleWidth+1]   ? 34'(-dev_ff)   : 34'(dev_ff);
   // signed quotient from magnitude: truncate toward zero
   assign dmag     = div_req.dividend_neg ? -div_q : div_q;
   assign mnew     = 35'(mean_ff) + 35'(signed'(dmag[SampleWidth+2:0]));
   assign dev_full = 35'(x_ff) - 35'(mean_ff);
   assign m2_sum   = {1'b0, m2_ff} + {1'b0, prod_ff};
   assign var_full = div_q >> 16;

   logic div_neg_ff, div_neg_in;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      x_in       = x_ff;
      miss_in    = miss_ff;
      inrange_in = inrange_ff;
      mean_in    = mean_ff;
      delta_in   = delta_ff;
      dev_in     = dev_ff;
      m2_in      = m2_ff;
      prod_in    = prod_ff;
      ovf_in     = ovf_ff;
      var_in     = var_ff;
      vv_in      = vv_ff;
      sm_in      = sm_ff;
      of_in      = of_ff;
      rv_in      = rv_ff;
      div_neg_in = div_neg_ff;
      wr_en      = 1'b0;
      div_req    = '0;
      div_req.dividend_neg = div_neg_ff;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in   = count_next;
               inrange_in = chain_ok && elem_ok;
               slot_in    = AddrWidth'(({30'd0, req_chain_index} * 32'(NUM_ELEMENTS))
                            + 32'(req_element_index[ElemWidth-1:0]));
               x_in       = 33'(req_sample);
               miss_in    = req_sample_missing;
               ovf_in     = 1'b0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // memory data valid now
            vv_in = 1'b0; var_in = '0; of_in = 1'b0; sm_in = 1'b0;
            if (!inrange_ff) begin
               rv_in = 1'b1; state_in = ST_IDLE;
            end else if (miss_ff || rd_miss) begin
               miss_in = 1'b1;
               mean_in = 33'(signed'(rd_mean));
               m2_in   = rd_m2;
               wr_en   = 1'b0;
               sm_in   = 1'b1;
               rv_in   = 1'b1;
               state_in = ST_OUT;
            end else if (count_ff == '0) begin
               rv_in = 1'b1; state_in = ST_IDLE;
            end else begin
               mean_in  = 33'(signed'(rd_mean));
               m2_in    = rd_m2;
               delta_in = 34'(x_ff) - 34'(signed'(rd_mean));
               state_in = ST_DIV_MEAN;
            end
         end
         ST_OUT: begin
            // write back the slot: updated mean and m2, or the missing flag with unchanged data
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DIV_MEAN: begin
            div_req.start        = 1'b1;
            div_req.dividend_neg = delta_ff[SampleWidth+1];
            div_req.dividend_mag = 64'(delta_mag);
            div_req.divisor      = count_ff;
            div_neg_in           = delta_ff[SampleWidth+1];
            state_in             = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               if (mnew > 35'sh07FFFFFFF) begin
                  mean_in = 33'sh07FFFFFFF; ovf_in = 1'b1;
               end else if (mnew < -35'sh080000000) begin
                  mean_in = -33'sh080000000; ovf_in = 1'b1;
               end else begin
                  mean_in = 33'(mnew);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            dev_in   = 34'(dev_full);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // dev_ff ready; product registered next
            prod_in  = 64'(delta_mag) * 64'(dev_mag);
            state_in = ST_DIV_VAR;
            if (delta_ff != '0 && dev_ff != '0
                && (delta_ff[SampleWidth+1] != dev_ff[SampleWidth+1])) begin
               prod_in = '0;
            end
         end
         ST_DIV_VAR: begin
            if (m2_sum[Sq_Width]) begin
               m2_in = '1; ovf_in = 1'b1;
            end else begin
               m2_in = m2_sum[Sq_Width-1:0];
            end
            wr_en = 1'b0;
            if (count_ff >= 32'd2) begin
               div_req.start        = 1'b1;
               div_req.dividend_neg = 1'b0;
               div_req.dividend_mag = m2_sum[Sq_Width] ? '1 : m2_sum[Sq_Width-1:0];
               div_req.divisor      = count_ff - 1'b1;
               div_neg_in           = 1'b0;
               state_in             = ST_VAR;
            end else begin
               of_in    = ovf_in;
               rv_in    = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_VAR: begin
            if (div_done) begin
               if (var_full[Sq_Width-1:VarWidth] != '0) begin
                  var_in = '1; of_in = 1'b1;
               end else begin
                  var_in = var_full[VarWidth-1:0]; of_in = ovf_ff;
               end
               vv_in    = 1'b1;
               rv_in    = 1'b1;
               state_in = ST_OUT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      slot_ff    <= slot_in;
      x_ff       <= x_in;
      miss_ff    <= miss_in;
      inrange_ff <= inrange_in;
      mean_ff    <= mean_in;
      delta_ff   <= delta_in;
      dev_ff     <= dev_in;
      m2_ff      <= m2_in;
      prod_ff    <= prod_in;
      ovf_ff     <= ovf_in;
      var_ff     <= var_in;
      vv_ff      <= vv_in;
      sm_ff      <= sm_in;
      of_ff      <= of_in;
      div_neg_ff <= div_neg_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_variance       = var_ff;
   assign rsp_variance_valid = vv_ff;
   assign rsp_slot_missing   = sm_ff;
   assign rsp_overflow       = of_ff;

endmodule
